// ===== sv/desq_pkg.sv =====
// ----------------------------------------------------------------------------
// desq_pkg
// shared types, constants and fixed-point helpers of the synapse block
// ----------------------------------------------------------------------------
package desq_pkg;

   localparam int MaxPendingDefault  = 64;
   localparam int MaxSynapsesDefault = 64;
   localparam int NumRegs            = 7;
   localparam logic [31:0] InvDtReset = 32'sd65536;

   typedef enum logic [1:0] {
      KIND_SPIKE = 2'd0,
      KIND_STEP  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_REINIT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_X_GAIN  = 3'd0,
      REG_X_DECAY = 3'd1,
      REG_Y_GAIN  = 3'd2,
      REG_Y_DECAY = 3'd3,
      REG_NORM    = 3'd4,
      REG_EK      = 3'd5,
      REG_INV_DT  = 3'd6
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOOKUP, ST_PUSH, ST_SWEEP, ST_SUM,
      ST_X0, ST_X1, ST_Y0, ST_Y1, ST_G, ST_I, ST_OUT
   } state_type;

   // control from the sequencer to the cell row
   typedef struct packed {
      logic        push;
      logic        sweep;
      logic        clear;
      logic [31:0] now;
      logic [31:0] push_due;
      logic [31:0] push_weight;
   } cell_ctrl_type;

   // round-half-up Q16.16 product of a 33-bit and a 32-bit signed value
   function automatic logic signed [48:0] qmul(input logic signed [32:0] a,
                                              input logic signed [31:0] b);
      logic signed [64:0] p;
      begin
         p = a * b + 65'sd32768;
         qmul = p[64:16];
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
      begin
         if (v > 56'sh7FFFFFFF) sat32 = 32'sh7FFFFFFF;
         else if (v < -56'sh80000000) sat32 = 32'sh80000000;
         else sat32 = v[31:0];
      end
   endfunction

endpackage

// ===== sv/desq_cell.sv =====
// ----------------------------------------------------------------------------
// desq_cell
// one queue slot: holds one pending event, hands it down the row on a sweep
// ----------------------------------------------------------------------------
module desq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  desq_pkg::cell_ctrl_type ctrl,
   input  logic                   is_tail,    // this slot is the first free one
   input  logic                   prev_valid,
   input  logic [31:0]            prev_due,
   input  logic [31:0]            prev_weight,
   output logic                   valid,
   output logic [31:0]            due,
   output logic [31:0]            weight
);
   import desq_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] due_ff, due_in, weight_ff, weight_in;

   always_comb begin
      valid_in  = valid_ff;
      due_in    = due_ff;
      weight_in = weight_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.push && is_tail) begin
         valid_in  = 1'b1;
         due_in    = ctrl.push_due;
         weight_in = ctrl.push_weight;
      end else if (ctrl.sweep) begin
         // a shift by one slot toward the head; the head slot is sampled by the accumulator
         valid_in  = prev_valid;
         due_in    = prev_due;
         weight_in = prev_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      due_ff    <= due_in;
      weight_ff <= weight_in;
   end

   assign valid  = valid_ff;
   assign due    = due_ff;
   assign weight = weight_ff;
endmodule

// ===== sv/desq_queue.sv =====
// ----------------------------------------------------------------------------
// desq_queue
// row of event cells; a sweep shifts the row once around, dropping due items
// ----------------------------------------------------------------------------
module desq_queue #(
   parameter int MaxPending = desq_pkg::MaxPendingDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  desq_pkg::cell_ctrl_type ctrl,
   output logic                    full,
   output logic                    head_hit,   // head slot is valid and due during a sweep
   output logic [31:0]             head_weight
);
   import desq_pkg::*;

   logic [MaxPending-1:0] valid;
   logic [31:0]           due    [MaxPending];
   logic [31:0]           weight [MaxPending];
   logic [MaxPending-1:0] tail;
   logic                  head_due;

   assign head_due    = valid[0] && (due[0] <= ctrl.now);
   assign head_hit    = ctrl.sweep && head_due;
   assign head_weight = weight[0];
   assign full        = valid[MaxPending-1];

   // slots stay packed from zero, so the tail is the first clear valid bit
   always_comb begin
      for (int i = 0; i < MaxPending; i++) begin
         if (i == 0) tail[i] = !valid[0];
         else tail[i] = valid[i-1] && !valid[i];
      end
   end

   for (genvar g = 0; g < MaxPending; g++) begin : g_cell
      logic        pv;
      logic [31:0] pd, pw;
      if (g == MaxPending - 1) begin : g_wrap
         // end slot only takes the kept head item, when the row is full
         assign pv = valid[g] && valid[0] && !head_due;
         assign pd = due[0];
         assign pw = weight[0];
      end else begin : g_link
         logic is_last;
         assign is_last = valid[g] && !valid[g+1];
         // a kept head item re-enters at the last valid slot after the shift
         assign pv = is_last ? (valid[0] && !head_due) : valid[g+1];
         assign pd = is_last ? due[0] : due[g+1];
         assign pw = is_last ? weight[0] : weight[g+1];
      end
      desq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .is_tail     (tail[g]),
         .prev_valid  (pv),
         .prev_due    (pd),
         .prev_weight (pw),
         .valid       (valid[g]),
         .due         (due[g]),
         .weight      (weight[g])
      );
   end
endmodule

// ===== sv/dual_exp_synapse_with_event_queue_top.sv =====
// ----------------------------------------------------------------------------
// dual_exp_synapse_with_event_queue_top
// dual-exponential synaptic conductance with a delayed-event cell queue
// ----------------------------------------------------------------------------
// spike: table read (lookup), then push; table write and reinit are done on accept in the idle state
// time step: a sweep through the cell row, then the shared multiplier chain and
// the output load; a stalled result holds the block in the output state;
// it takes one item at a time; reset empties the queue, zeroes the table valid bits,
// stages and flags, and loads inv_dt with 1.0
module dual_exp_synapse_with_event_queue_top #(
   parameter int MAX_PENDING  = desq_pkg::MaxPendingDefault,
   parameter int MAX_SYNAPSES = desq_pkg::MaxSynapsesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [5:0]  req_synapse_index,
   input  logic signed [31:0] req_syn_weight,
   input  logic [15:0] req_syn_delay,
   input  logic [31:0] req_time_now,
   input  logic signed [31:0] req_membrane_voltage,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_conductance,
   output logic signed [31:0] rsp_channel_current,
   output logic        rsp_events_dropped,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import desq_pkg::*;

   localparam int SynW = (MAX_SYNAPSES > 1) ? $clog2(MAX_SYNAPSES) : 1;
   localparam int CntW = $clog2(MAX_PENDING + 1);

   logic signed [31:0] regs_ff [NumRegs];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++)
            regs_ff[i] <= (i == int'(REG_INV_DT)) ? InvDtReset : '0;
      end else if (csr_write && csr_index < 3'(NumRegs)) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   // synapse table memory, valid bits give the zero reset
   logic [47:0]             tab_mem [MAX_SYNAPSES];
   logic [MAX_SYNAPSES-1:0] tab_valid_ff;
   logic [47:0]             tab_rd_ff;
   logic                    tab_rd_valid_ff;

   state_type state_ff, state_in;
   logic [SynW-1:0]   idx_ff;
   logic [31:0]       now_ff;
   logic signed [31:0] vm_ff;
   logic [CntW-1:0]   cnt_ff;
   logic signed [55:0] acc_ff;
   logic signed [31:0] act_ff, x_ff, y_ff, gk_ff, ik_ff;
   logic signed [48:0] prod_ff;
   logic              drop_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_load;
   logic signed [31:0] rsp_g_ff, rsp_i_ff;
   logic              rsp_d_ff;

   logic accept;
   logic idx_ok;
   assign idx_ok = ({26'd0, req_synapse_index} < 32'(MAX_SYNAPSES));
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;

   // in ST_OUT, the output register loads when empty or when its item leaves this cycle
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   cell_ctrl_type ctrl;
   logic full, head_hit;
   logic [31:0] head_weight;
   logic [32:0] due_sum;

   wire tab_row_valid = tab_rd_valid_ff;
   wire [31:0] tab_w = tab_row_valid ? tab_rd_ff[47:16] : 32'd0;
   wire [15:0] tab_d = tab_row_valid ? tab_rd_ff[15:0]  : 16'd0;
   assign due_sum = {1'b0, now_ff} + {17'd0, tab_d};

   always_comb begin
      ctrl.push        = (state_ff == ST_PUSH) && !full;
      ctrl.sweep       = (state_ff == ST_SWEEP);
      ctrl.clear       = accept && (kind_type'(req_kind) == KIND_REINIT);
      ctrl.now         = now_ff;
      ctrl.push_due    = due_sum[32] ? 32'hFFFFFFFF : due_sum[31:0];
      ctrl.push_weight = tab_w;
   end

   desq_queue #(.MaxPending(MAX_PENDING)) u_queue (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .full        (full),
      .head_hit    (head_hit),
      .head_weight (head_weight)
   );

   always_ff @(posedge clock) begin
      if (accept && kind_type'(req_kind) == KIND_WRITE && idx_ok)
         tab_mem[req_synapse_index[SynW-1:0]] <= {req_syn_weight, req_syn_delay};
      tab_rd_ff <= tab_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) tab_valid_ff <= '0;
      else if (accept && kind_type'(req_kind) == KIND_WRITE && idx_ok)
         tab_valid_ff[req_synapse_index[SynW-1:0]] <= 1'b1;
   end
   always_ff @(posedge clock) tab_rd_valid_ff <= tab_valid_ff[idx_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (kind_type'(req_kind))
                  KIND_SPIKE: if (idx_ok) state_in = ST_LOOKUP;
                  KIND_STEP:  state_in = ST_SWEEP;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOKUP: state_in = ST_PUSH;
         ST_PUSH:   state_in = ST_IDLE;
         ST_SWEEP:  if (cnt_ff == CntW'(MAX_PENDING - 1)) state_in = ST_SUM;
         ST_SUM:    state_in = ST_X0;
         ST_X0:     state_in = ST_X1;
         ST_X1:     state_in = ST_Y0;
         ST_Y0:     state_in = ST_Y1;
         ST_Y1:     state_in = ST_G;
         ST_G:      state_in = ST_I;
         ST_I:      state_in = ST_OUT;
         ST_OUT:    if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // one shared multiplier, operands chosen per state
   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [48:0] mul_p;
   always_comb begin
      mul_a = 33'(signed'(head_weight));
      mul_b = regs_ff[REG_INV_DT];
      case (state_ff)
         ST_SUM:  begin mul_a = 33'(act_ff); mul_b = regs_ff[REG_X_GAIN];  end
         ST_X0:   begin mul_a = 33'(x_ff);   mul_b = regs_ff[REG_X_DECAY]; end
         ST_X1:   begin mul_a = 33'(x_ff);   mul_b = regs_ff[REG_Y_GAIN];  end
         ST_Y0:   begin mul_a = 33'(y_ff);   mul_b = regs_ff[REG_Y_DECAY]; end
         ST_Y1:   begin mul_a = 33'(y_ff);   mul_b = regs_ff[REG_NORM];    end
         ST_G: begin
            mul_a = 33'(regs_ff[REG_EK]) - 33'(vm_ff);
            mul_b = gk_ff;
         end
         default: begin
            mul_a = 33'(signed'(head_weight));
            mul_b = regs_ff[REG_INV_DT];
         end
      endcase
      mul_p = qmul(mul_a, mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               acc_ff <= '0;
               if (accept) begin
                  idx_ff  <= req_synapse_index[SynW-1:0];
                  now_ff  <= req_time_now;
                  vm_ff   <= req_membrane_voltage;
               end
            end
            ST_PUSH: if (full) drop_ff <= 1'b1;
            ST_SWEEP: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (head_hit) acc_ff <= acc_ff + 56'(mul_p);
            end
            ST_SUM:  prod_ff <= mul_p;
            ST_X0:   x_ff <= sat32(56'(prod_ff) + 56'(mul_p));
            ST_X1:   prod_ff <= mul_p;
            ST_Y0:   y_ff <= sat32(56'(prod_ff) + 56'(mul_p));
            ST_Y1:   gk_ff <= sat32(56'(mul_p));
            ST_G:    ik_ff <= sat32(56'(mul_p));
            ST_I: ;
            ST_OUT: begin
               if (rsp_load) begin
                  rsp_g_ff <= gk_ff;
                  rsp_i_ff <= ik_ff;
                  rsp_d_ff <= drop_ff;
                  drop_ff  <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // activation saturates once after the sweep
   always_ff @(posedge clock) begin
      if (state_ff == ST_SWEEP && state_in == ST_SUM) act_ff <= sat32(acc_ff +
         (head_hit ? 56'(mul_p) : 56'sd0));
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_conductance     = rsp_g_ff;
   assign rsp_channel_current = rsp_i_ff;
   assign rsp_events_dropped  = rsp_d_ff;
endmodule

// ===== dv/tb_dual_exp_synapse_with_event_queue_top.sv =====
// ----------------------------------------------------------------------------
// tb_dual_exp_synapse_with_event_queue_top
// checks spike queueing, step conductance and current against a local model
// ----------------------------------------------------------------------------
// directed items cover table writes at the index and weight extremes, due-time
// saturation, full-queue drops, reinit and register extremes; random phases
// mix spikes, steps, table writes and reinits with random idle on both channels
module tb_dual_exp_synapse_with_event_queue_top;
   import desq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH = MaxPendingDefault;

   typedef struct packed {
      logic signed [31:0] gk;
      logic signed [31:0] ik;
      logic               dropped;
   } step_out_type;

   class synapse_scoreboard;
      logic signed [31:0] regs [NumRegs];
      logic [31:0]        ev_due [$];
      logic signed [31:0] ev_wt [$];
      logic signed [31:0] tab_wt [64];
      logic [15:0]        tab_dly [64];
      logic signed [31:0] x_st, y_st;
      bit                 drop;
      step_out_type       pending_out [$];
      int                 errors, checked;

      function new();
         foreach (regs[i]) regs[i] = 0;
         regs[REG_INV_DT] = 32'sd65536;
         foreach (tab_wt[i]) begin
            tab_wt[i] = 0;
            tab_dly[i] = 0;
         end
         x_st = 0; y_st = 0; drop = 0; errors = 0; checked = 0;
      endfunction

      function longint fx_mul(longint a, longint b);
         longint p;
         p = a * b + 32768;
         return p >>> 16;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function void note_item(kind_type k, logic [5:0] idx, logic signed [31:0] wt,
                              logic [15:0] dly, logic [31:0] now,
                              logic signed [31:0] vm);
         longint acc, due, gk, ik;
         logic [31:0] kd [$];
         logic signed [31:0] kw [$];
         step_out_type o;
         case (k)
            KIND_SPIKE: begin
               if (ev_due.size() >= QDEPTH) drop = 1;
               else begin
                  due = longint'(now) + longint'(tab_dly[idx]);
                  if (due > 64'hFFFFFFFF) due = 64'hFFFFFFFF;
                  ev_due = {ev_due, due[31:0]};
                  ev_wt = {ev_wt, tab_wt[idx]};
               end
            end
            KIND_WRITE: begin
               tab_wt[idx] = wt;
               tab_dly[idx] = dly;
            end
            KIND_REINIT: begin
               ev_due.delete();
               ev_wt.delete();
            end
            default: begin
               acc = 0;
               foreach (ev_due[i]) begin
                  if (ev_due[i] <= now) acc += fx_mul(ev_wt[i], regs[REG_INV_DT]);
                  else begin
                     kd = {kd, ev_due[i]};
                     kw = {kw, ev_wt[i]};
                  end
               end
               ev_due = kd;
               ev_wt = kw;
               acc = clamp32(acc);
               x_st = 32'(clamp32(fx_mul(acc, regs[REG_X_GAIN]) +
                                  fx_mul(x_st, regs[REG_X_DECAY])));
               y_st = 32'(clamp32(fx_mul(x_st, regs[REG_Y_GAIN]) +
                                  fx_mul(y_st, regs[REG_Y_DECAY])));
               gk = clamp32(fx_mul(y_st, regs[REG_NORM]));
               ik = clamp32(fx_mul(longint'(regs[REG_EK]) - longint'(vm), gk));
               o.gk = gk[31:0];
               o.ik = ik[31:0];
               o.dropped = drop;
               pending_out = {pending_out, o};
               drop = 0;
            end
         endcase
      endfunction

      function void check_step(logic signed [31:0] gk, logic signed [31:0] ik, logic d);
         step_out_type e;
         checked++;
         if (pending_out.size() == 0) begin
            $error("unexpected step result gk=%0d ik=%0d", gk, ik);
            errors++;
            return;
         end
         e = pending_out.pop_front();
         if (gk !== e.gk) begin
            $error("conductance: expected %0d actual %0d", e.gk, gk);
            errors++;
         end
         if (ik !== e.ik) begin
            $error("channel_current: expected %0d actual %0d", e.ik, ik);
            errors++;
         end
         if (d !== e.dropped) begin
            $error("events_dropped: expected %0d actual %0d", e.dropped, d);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [1:0] req_kind = 0;
   logic [5:0] req_synapse_index = 0;
   logic signed [31:0] req_syn_weight = 0;
   logic [15:0] req_syn_delay = 0;
   logic [31:0] req_time_now = 0;
   logic signed [31:0] req_membrane_voltage = 0;
   logic rsp_valid, rsp_stall = 0;
   logic signed [31:0] rsp_conductance, rsp_channel_current;
   logic rsp_events_dropped;
   logic csr_write = 0;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   synapse_scoreboard sb = new();
   bit no_idle = 0;
   logic [31:0] sim_now = 0;
   int n_spikes = 0, n_steps = 0;

   dual_exp_synapse_with_event_queue_top DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #50ms;
      $display("Simulation FAILED");
      $finish;
   end

   // result side: random stall, checks on accept
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_step(rsp_conductance, rsp_channel_current, rsp_events_dropped);
      rsp_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 29);
   end

   // valid stays high after an accept until the next item or an idle cycle
   task automatic send_item(kind_type k, logic [5:0] idx, logic signed [31:0] wt,
                            logic [15:0] dly, logic [31:0] now, logic signed [31:0] vm);
      while (!no_idle && $urandom_range(99) < 29) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= k;
      req_synapse_index <= idx;
      req_syn_weight <= wt;
      req_syn_delay <= dly;
      req_time_now <= now;
      req_membrane_voltage <= vm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(k, idx, wt, dly, now, vm);
      if (k == KIND_SPIKE) n_spikes++;
      if (k == KIND_STEP) n_steps++;
   endtask

   task automatic write_reg(reg_index_type r, logic [31:0] v);
      csr_write <= 1;
      csr_index <= r;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
      sb.regs[r] = v;
      @(posedge clock);
   endtask

   task automatic drain();
      int n;
      n = 0;
      req_valid <= 0;
      while (sb.pending_out.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (QDEPTH + 20) @(posedge clock);
   endtask

   task automatic step_at(logic [31:0] now);
      send_item(KIND_STEP, 0, 0, 0, now, $urandom());
   endtask

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(3))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h00010000;
         default: return $urandom();
      endcase
   endfunction

   task automatic random_phase(int items, bit wild);
      int k;
      for (int i = 0; i < items; i++) begin
         no_idle = (i >= items / 3 && i < items / 2);
         k = $urandom_range(99);
         sim_now += $urandom_range(3);
         if (k < 45)
            send_item(KIND_SPIKE, 6'($urandom()), 0, 0, wild ? $urandom() : sim_now, 0);
         else if (k < 80)
            send_item(KIND_STEP, 0, 0, 0, wild ? $urandom() : sim_now, $urandom());
         else if (k < 95)
            send_item(KIND_WRITE, 6'($urandom()),
                      wild ? $urandom() : 32'($urandom_range(200000) - 100000),
                      16'(wild ? $urandom() : $urandom_range(6)), 0, 0);
         else
            send_item(KIND_REINIT, 0, 0, 0, 0, 0);
      end
      no_idle = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes of table, saturation of due time, full queue, reinit
      send_item(KIND_WRITE, 6'd0, 32'sh7FFFFFFF, 16'hFFFF, 0, 0);
      send_item(KIND_WRITE, 6'd63, 32'sh80000000, 16'd0, 0, 0);
      send_item(KIND_SPIKE, 6'd0, 0, 0, 32'hFFFFFFF0, 0);
      send_item(KIND_SPIKE, 6'd63, 0, 0, 32'd5, 0);
      send_item(KIND_STEP, 0, 0, 0, 32'd5, 32'sh7FFFFFFF);
      send_item(KIND_STEP, 0, 0, 0, 32'hFFFFFFFF, 32'sh80000000);
      for (int i = 0; i < QDEPTH + 2; i++) send_item(KIND_SPIKE, 6'd63, 0, 0, 0, 0);
      send_item(KIND_REINIT, 0, 0, 0, 0, 0);
      step_at(32'hFFFFFFFF);
      step_at(0);
      drain();
      write_reg(REG_X_GAIN, 32'h00010000);
      write_reg(REG_X_DECAY, 32'h00008000);
      write_reg(REG_Y_GAIN, 32'h00010000);
      write_reg(REG_Y_DECAY, 32'h0000C000);
      write_reg(REG_NORM, 32'h00020000);
      write_reg(REG_EK, 32'h00400000);
      write_reg(REG_INV_DT, 32'h00010000);
      sim_now = 0;
      random_phase(600, 0);
      drain();
      foreach (sb.regs[r]) write_reg(reg_index_type'(r), pick_extreme());
      random_phase(450, 1);
      drain();
      foreach (sb.regs[r]) write_reg(reg_index_type'(r), $urandom());
      random_phase(350, 1);
      drain();
      write_reg(REG_INV_DT, 32'h80000000);
      write_reg(REG_EK, 32'h7FFFFFFF);
      write_reg(REG_X_GAIN, 32'h7FFFFFFF);
      write_reg(REG_NORM, 32'h7FFFFFFF);
      write_reg(REG_Y_GAIN, 32'h7FFFFFFF);
      sim_now = 0;
      random_phase(350, 0);
      drain();
      $display("covered %0d spikes and %0d steps, %0d results checked",
               n_spikes, n_steps, sb.checked);
      if (sb.errors == 0 && sb.pending_out.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// ===== dual_exp_synapse_with_event_queue_top.f =====
sv/desq_pkg.sv
sv/desq_cell.sv
sv/desq_queue.sv
sv/dual_exp_synapse_with_event_queue_top.sv
dv/tb_dual_exp_synapse_with_event_queue_top.sv
